[rtl/minid_pkg.sv]
// Package for the minimum-image neighbor displacement block.
// Holds field widths, status codes, the sequencer state type and the divider status struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package minid_pkg;

    // Fixed field widths
    localparam int POS_W    = 32;
    localparam int DIFF_W   = 33;
    localparam int COEF_W   = 21;
    localparam int REG_W    = 63;
    localparam int PROD_W   = DIFF_W + COEF_W;
    localparam int FRAC_W   = PROD_W + 2;
    localparam int WRAP_W   = 34;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 8;
    localparam int MEAN_W   = SUM_W + 1;
    localparam int DISP_W   = MEAN_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CELL_A = 3'd0;
    localparam logic [2:0] REG_CELL_B = 3'd1;
    localparam logic [2:0] REG_CELL_C = 3'd2;
    localparam logic [2:0] REG_INV_A  = 3'd3;
    localparam logic [2:0] REG_INV_B  = 3'd4;
    localparam logic [2:0] REG_INV_C  = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_SUM,
        ST_END,
        ST_DIV,
        ST_DIVW,
        ST_FIN
    } minid_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/minid_divider.sv]
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Divides a 40-bit signed sum by an 8-bit nonzero count. Uses minid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module minid_divider (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [minid_pkg::SUM_W-1:0]   dividend,
    input  wire logic        [minid_pkg::CNT_W-1:0]   divisor,
    output logic signed      [minid_pkg::MEAN_W-1:0]  quotient,
    output minid_pkg::div_stat_t                      stat
);
    import minid_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     dvs_reg;
    logic                 neg_reg;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_sub;
    logic                 qbit;
    logic [MEAN_W-1:0]    quo_ext;

    // Restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        qbit      = (trial >= {1'b0, dvs_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath: magnitude in, quotient bits shift in from the right
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], qbit};
        end
    end

    assign quo_ext   = {1'b0, quo_reg};
    assign quotient  = neg_reg ? signed'(~quo_ext + 1'b1) : signed'(quo_ext);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[rtl/min_image_neighbor_displacement_top.sv]
// Minimum-image neighbor displacement: top level, sequencer and shared multiplier.
// Neighbor item: accept, nine multiplies on one 33x21 multiplier, drain, sum.
// Center item, or neighbor past the limit: accepted with no further steps. Group end adds status and output steps,
// plus three divisions when ok (each: start, 40 steps, done).
// A finished result sits in the output register; new items are taken while it waits.
// Reset (async, rst_n low) clears config registers, center, sums, count and flags.
// Depends on minid_pkg and minid_divider.
`timescale 1ns / 1ps
`default_nettype none

module min_image_neighbor_displacement_top #(
    parameter int MAX_NEIGHBORS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [2:0]                          cfg_index,
    input  wire logic [minid_pkg::REG_W-1:0]         cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic signed [minid_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [minid_pkg::POS_W-1:0]  pos_y,
    input  wire logic signed [minid_pkg::POS_W-1:0]  pos_z,
    input  wire logic                                group_end,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [minid_pkg::POS_W-1:0]       center_x,
    output logic signed [minid_pkg::POS_W-1:0]       center_y,
    output logic signed [minid_pkg::POS_W-1:0]       center_z,
    output logic signed [minid_pkg::POS_W-1:0]       disp_x,
    output logic signed [minid_pkg::POS_W-1:0]       disp_y,
    output logic signed [minid_pkg::POS_W-1:0]       disp_z,
    output logic [1:0]                               status
);
    import minid_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NEIGHBORS);
    localparam logic signed [FRAC_W-1:0] FRAC_HALF = FRAC_W'(64'sd1 <<< 35);

    // Signed 21-bit field i of a packed register
    function automatic logic signed [COEF_W-1:0] field21(
        input logic [REG_W-1:0] r,
        input logic [1:0]       i
    );
        logic signed [COEF_W-1:0] f;
        case (i)
            2'd0:    f = r[20:0];
            2'd1:    f = r[41:21];
            default: f = r[62:42];
        endcase
        return f;
    endfunction

    // Lattice component scaled from Q10.10 to Q.16, kept signed
    function automatic logic signed [COEF_W+5:0] row_q16(
        input logic [REG_W-1:0] r,
        input logic [1:0]       i
    );
        return {field21(r, i), 6'b0};
    endfunction

    minid_state_t state_reg, state_next;

    logic [REG_W-1:0]               cell_row_reg [3];
    logic [REG_W-1:0]               inv_col_reg  [3];

    logic signed [POS_W-1:0]        center_reg  [3];
    logic signed [SUM_W-1:0]        sum_reg     [3];
    logic [CNT_W-1:0]               count_reg;
    logic                           overflow_reg;
    logic                           last_reg;

    logic signed [DIFF_W-1:0]       diff_reg    [3];
    logic signed [WRAP_W-1:0]       wrapped_reg [3];
    logic [1:0]                     i_reg;
    logic [1:0]                     k_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           prod_valid_reg;
    logic                           prod_last_reg;
    logic [1:0]                     prod_k_reg;
    logic signed [FRAC_W-1:0]       acc_reg;

    logic [1:0]                     c_reg;
    logic [1:0]                     res_status_reg;
    logic signed [POS_W-1:0]        disp_res_reg [3];

    logic                           out_valid_reg;
    logic signed [POS_W-1:0]        out_center_reg [3];
    logic signed [POS_W-1:0]        out_disp_reg   [3];
    logic [1:0]                     out_status_reg;

    logic                           accept;
    logic                           div_start;
    logic                           out_free;
    logic signed [POS_W-1:0]        pos_in [3];
    logic signed [DIFF_W-1:0]       diff_sel;
    logic signed [COEF_W-1:0]       inv_sel;
    logic signed [PROD_W-1:0]       prod;
    logic signed [FRAC_W-1:0]       frac;
    logic signed [MEAN_W-1:0]       mean;
    logic signed [DISP_W-1:0]       disp_full;
    logic signed [POS_W-1:0]        disp_sat;
    div_stat_t                      div_stat;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 3; n++)
            begin
                cell_row_reg[n] <= '0;
                inv_col_reg[n]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_A: cell_row_reg[0] <= cfg_data;
                REG_CELL_B: cell_row_reg[1] <= cfg_data;
                REG_CELL_C: cell_row_reg[2] <= cfg_data;
                REG_INV_A:  inv_col_reg[0]  <= cfg_data;
                REG_INV_B:  inv_col_reg[1]  <= cfg_data;
                REG_INV_C:  inv_col_reg[2]  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and sequencer outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode && (count_reg < MAX_CNT))
                        state_next = ST_MUL;
                    else if (group_end)
                        state_next = ST_END;
                end
            end
            ST_MUL:
            begin
                if (i_reg == 2'd2 && k_reg == 2'd2)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_SUM;
            ST_SUM:
                state_next = last_reg ? ST_END : ST_IDLE;
            ST_END:
            begin
                if (overflow_reg || count_reg == '0)
                    state_next = ST_FIN;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                    state_next = (c_reg == 2'd2) ? ST_FIN : ST_DIV;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Shared multiplier: one diff * inverse entry per cycle
    assign diff_sel = diff_reg[i_reg];
    assign inv_sel  = field21(inv_col_reg[k_reg], i_reg);
    assign prod     = diff_sel * inv_sel;
    assign frac     = acc_reg + FRAC_W'(prod_reg);

    // Mean and saturated displacement for the component in the divider
    assign disp_full = DISP_W'(center_reg[c_reg]) - DISP_W'(mean);
    always_comb
    begin
        if (disp_full[DISP_W-1:POS_W-1] == '0 || disp_full[DISP_W-1:POS_W-1] == '1)
            disp_sat = disp_full[POS_W-1:0];
        else if (disp_full[DISP_W-1])
            disp_sat = {1'b1, {(POS_W-1){1'b0}}};
        else
            disp_sat = {1'b0, {(POS_W-1){1'b1}}};
    end

    minid_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[c_reg]),
        .divisor  (count_reg),
        .quotient (mean),
        .stat     (div_stat)
    );

    // Group state: center, sums, count, overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 3; n++)
            begin
                center_reg[n] <= '0;
                sum_reg[n]    <= '0;
            end
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (accept && !mode)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    center_reg[n] <= pos_in[n];
                    sum_reg[n]    <= '0;
                end
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else if (accept && count_reg >= MAX_CNT)
                overflow_reg <= 1'b1;
            else if (state_reg == ST_SUM)
            begin
                for (int n = 0; n < 3; n++)
                    sum_reg[n] <= sum_reg[n] + SUM_W'(wrapped_reg[n]);
                count_reg <= count_reg + 1'b1;
            end
            else if (state_reg == ST_FIN && out_free)
            begin
                for (int n = 0; n < 3; n++)
                    sum_reg[n] <= '0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    // Sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            k_reg          <= '0;
            prod_valid_reg <= 1'b0;
            c_reg          <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= (state_reg == ST_MUL);
            if (accept)
            begin
                i_reg    <= '0;
                k_reg    <= '0;
                last_reg <= group_end;
            end
            else if (state_reg == ST_MUL)
            begin
                if (i_reg == 2'd2)
                begin
                    i_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                end
                else
                    i_reg <= i_reg + 1'b1;
            end
            if (state_reg == ST_END)
                c_reg <= '0;
            else if (state_reg == ST_DIVW && div_stat.done)
                c_reg <= c_reg + 1'b1;
        end
    end

    // Neighbor datapath: diff load, product pipeline, accumulate and wrap
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int n = 0; n < 3; n++)
            begin
                diff_reg[n]    <= DIFF_W'(pos_in[n]) - DIFF_W'(center_reg[n]);
                wrapped_reg[n] <= WRAP_W'(pos_in[n]);
            end
            acc_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg      <= prod;
            prod_last_reg <= (i_reg == 2'd2);
            prod_k_reg    <= k_reg;
        end
        if (prod_valid_reg)
        begin
            if (prod_last_reg)
            begin
                acc_reg <= '0;
                for (int n = 0; n < 3; n++)
                begin
                    if (frac > FRAC_HALF)
                        wrapped_reg[n] <= wrapped_reg[n]
                            - WRAP_W'(row_q16(cell_row_reg[prod_k_reg], 2'(n)));
                    else if (frac < -FRAC_HALF)
                        wrapped_reg[n] <= wrapped_reg[n]
                            + WRAP_W'(row_q16(cell_row_reg[prod_k_reg], 2'(n)));
                end
            end
            else
                acc_reg <= frac;
        end
    end

    // Result status and per-component displacement
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_END)
        begin
            if (overflow_reg)
                res_status_reg <= STATUS_OVERFLOW;
            else if (count_reg == '0)
                res_status_reg <= STATUS_EMPTY;
            else
                res_status_reg <= STATUS_OK;
        end
        if (state_reg == ST_DIVW && div_stat.done)
            disp_res_reg[c_reg] <= disp_sat;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_FIN && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            for (int n = 0; n < 3; n++)
            begin
                out_center_reg[n] <= center_reg[n];
                out_disp_reg[n]   <= (res_status_reg == STATUS_OK) ? disp_res_reg[n] : '0;
            end
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign center_x  = out_center_reg[0];
    assign center_y  = out_center_reg[1];
    assign center_z  = out_center_reg[2];
    assign disp_x    = out_disp_reg[0];
    assign disp_y    = out_disp_reg[1];
    assign disp_z    = out_disp_reg[2];
    assign status    = out_status_reg;

    // Assertions
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("neighbor count above maximum");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> count_reg == MAX_CNT)
        else $error("overflow flag set with room left");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIVW)
        else $error("divider finished outside wait state");

endmodule

`default_nettype wire
